@@ rtl/core/ffsa_pkg.sv @@
// Shared types and constants for the first-fit slot allocator.
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int SLOT_W      = 12;
  localparam int UNITS_W     = 13;
  localparam int BYTES_W     = 21;
  localparam int OFFSET_W    = 22;
  localparam int CAP_W       = 13;
  localparam int INC_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int CAP_REG_MAX = (2 ** CAP_W) - 1;

  // 0x100-byte slots
  localparam int SLOT_SHIFT  = 8;

  localparam int DEF_HEAP_SLOTS   = 4096;
  localparam int DEF_FREE_ENTRIES = 16;

  localparam logic [CAP_W-1:0] INIT_CAP_RST = CAP_W'(256);
  localparam logic [INC_W-1:0] HANDLE_INC_RST = INC_W'(32);

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HANDLE_INC = CFG_IDX_W'(1);

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOC      = 2'd0,
    ST_RELEASE    = 2'd1,
    ST_CAP_LIMIT  = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  start;
    logic [UNITS_W-1:0] len;
  } span_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_DROP,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    span_t    data;
  } cell_cmd_t;

endpackage

@@ rtl/core/ffsa_if.sv @@
// Channel interfaces: request, result and register write.
`timescale 1ns / 1ps
interface ffsa_in_if import ffsa_pkg::*;;
  logic               valid;
  logic               ready;
  logic               func;
  logic [BYTES_W-1:0] alloc_bytes;
  logic [SLOT_W-1:0]  release_start;
  logic [UNITS_W-1:0] release_units;

  modport source (output valid, func, alloc_bytes, release_start, release_units,
                  input ready);
  modport sink   (input valid, func, alloc_bytes, release_start, release_units,
                  output ready);
endinterface

interface ffsa_out_if import ffsa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [OFFSET_W-1:0] descriptor_offset;
  logic [1:0]          status;
  logic                grew;
  logic [CAP_W-1:0]    capacity;
  logic [UNITS_W-1:0]  next_free;

  modport source (output valid, slot, descriptor_offset, status, grew, capacity,
                  next_free, input ready);
  modport sink   (input valid, slot, descriptor_offset, status, grew, capacity,
                  next_free, output ready);
endinterface

interface ffsa_cfg_if import ffsa_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/ffsa_cell.sv @@
// One free-span cell of the rotating span ring.
`timescale 1ns / 1ps
module ffsa_cell import ffsa_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  cell_cmd_t       cmd_i,
  input  logic [CW-1:0]   pos_i,
  input  span_t           next_i,
  output span_t           span_o
);

  span_t span_r;
  span_t span_nxt;
  logic  at_pos;

  assign at_pos = (pos_i == CW'(IDX));

  always_comb begin
    span_nxt = span_r;
    case (cmd_i.op)
      CELL_HOLD:   span_nxt = span_r;
      // tail of the live ring takes the (possibly updated) head word
      CELL_ROTATE: span_nxt = at_pos ? cmd_i.data : next_i;
      CELL_DROP:   span_nxt = next_i;
      CELL_LOAD:   span_nxt = at_pos ? cmd_i.data : span_r;
      default:     span_nxt = span_r;
    endcase
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
  end

  assign span_o = span_r;

endmodule

@@ rtl/core/first_fit_slot_allocator_top.sv @@
// Sequence: a release passes S_DECIDE and S_EMIT from accept to result valid; an allocate
//   first scans N = live free-span entries (0..FREE_ENTRIES) in S_SCAN.
// Flow: one request in flight, a new one taken only in S_IDLE; the span ring rotates one entry
//   per cycle past the head compare, and a full lap restores table order.
// Reset (sync, rst_n low): control idle, no spans, bump pointer 0,
//   capacity 256, handle increment 32; span cell contents left as is.
`timescale 1ns / 1ps
module first_fit_slot_allocator_top import ffsa_pkg::*; #(
  parameter int HEAP_SLOTS   = DEF_HEAP_SLOTS,
  parameter int FREE_ENTRIES = DEF_FREE_ENTRIES
) (
  input  logic          clk,
  input  logic          rst_n,
  ffsa_in_if.sink       in_ch,
  ffsa_out_if.source    out_ch,
  ffsa_cfg_if.sink      cfg_ch
);

  localparam int CW      = $clog2(FREE_ENTRIES + 1);
  localparam int CAP_MAX = (HEAP_SLOTS > CAP_REG_MAX) ? HEAP_SLOTS : CAP_REG_MAX;
  localparam int STW     = $clog2(CAP_MAX + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       steps_r;
  logic                found_r;
  logic [SLOT_W-1:0]   fslot_r;
  logic [STW-1:0]      bump_r;
  logic [STW-1:0]      cap_r;
  logic [INC_W-1:0]    inc_r;
  logic                func_r;
  logic [UNITS_W-1:0]  need_r;
  span_t               rel_r;
  logic [SLOT_W-1:0]   res_slot_r;
  status_t             res_status_r;
  logic                res_grew_r;

  logic                out_valid_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [OFFSET_W-1:0] out_offset_r;
  status_t             out_status_r;
  logic                out_grew_r;
  logic [CAP_W-1:0]    out_cap_r;
  logic [UNITS_W-1:0]  out_next_r;

  span_t               spans [FREE_ENTRIES];
  span_t               head;
  cell_cmd_t           cmd;
  logic [CW-1:0]       pos;
  logic                fits;
  logic                hit;
  logic [SLOT_W-1:0]   new_start;
  logic [UNITS_W-1:0]  new_len;
  logic [STW:0]        end_w;
  logic [STW:0]        doubled;
  logic                table_full;
  logic                in_acc;
  logic                out_free;

  // ring of span cells, cell 0 is the head under test
  for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_cell
    span_t nb;
    if (i == FREE_ENTRIES - 1) begin : g_last
      assign nb = spans[0];
    end else begin : g_mid
      assign nb = spans[i+1];
    end
    ffsa_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk    (clk),
      .cmd_i  (cmd),
      .pos_i  (pos),
      .next_i (nb),
      .span_o (spans[i])
    );
  end

  assign head       = spans[0];
  assign fits       = (head.len >= need_r);
  assign hit        = (state_r == S_SCAN) && (steps_r != '0) && !found_r && fits;
  assign new_start  = head.start + need_r[SLOT_W-1:0];
  assign new_len    = head.len - need_r;
  assign end_w      = {1'b0, bump_r} + (STW+1)'(need_r);
  assign doubled    = {cap_r, 1'b0};
  assign table_full = (count_r == CW'(FREE_ENTRIES));
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;

  always_comb begin
    cmd.op   = CELL_HOLD;
    cmd.data = head;
    pos      = count_r - CW'(1);
    if (state_r == S_SCAN && steps_r != '0) begin
      if (hit && new_len == '0) begin
        cmd.op = CELL_DROP;
      end else if (hit) begin
        cmd.op   = CELL_ROTATE;
        cmd.data = '{start: new_start, len: new_len};
      end else begin
        cmd.op = CELL_ROTATE;
      end
    end else if (state_r == S_DECIDE && func_r == FUNC_RELEASE && !table_full) begin
      cmd.op   = CELL_LOAD;
      cmd.data = rel_r;
      pos      = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      found_r     <= 1'b0;
      bump_r      <= '0;
      cap_r       <= STW'(INIT_CAP_RST);
      inc_r       <= HANDLE_INC_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r  <= in_ch.func;
            need_r  <= UNITS_W'(in_ch.alloc_bytes >> SLOT_SHIFT);
            rel_r   <= '{start: in_ch.release_start, len: in_ch.release_units};
            steps_r <= count_r;
            found_r <= 1'b0;
            state_r <= (in_ch.func == FUNC_ALLOC) ? S_SCAN : S_DECIDE;
          end
        end
        S_SCAN: begin
          if (steps_r == '0) begin
            state_r <= S_DECIDE;
          end else begin
            steps_r <= steps_r - CW'(1);
            if (hit) begin
              found_r <= 1'b1;
              fslot_r <= head.start;
              if (new_len == '0) begin
                count_r <= count_r - CW'(1);
              end
            end
          end
        end
        S_DECIDE: begin
          if (func_r == FUNC_RELEASE) begin
            res_slot_r <= '0;
            res_grew_r <= 1'b0;
            if (table_full) begin
              res_status_r <= ST_TABLE_FULL;
            end else begin
              res_status_r <= ST_RELEASE;
              count_r      <= count_r + CW'(1);
            end
          end else if (found_r) begin
            res_status_r <= ST_ALLOC;
            res_slot_r   <= fslot_r;
            res_grew_r   <= 1'b0;
          end else if (end_w > {1'b0, cap_r}) begin
            if (doubled > (STW+1)'(HEAP_SLOTS) || end_w > doubled) begin
              res_status_r <= ST_CAP_LIMIT;
              res_slot_r   <= '0;
              res_grew_r   <= 1'b0;
            end else begin
              res_status_r <= ST_ALLOC;
              res_grew_r   <= 1'b1;
              res_slot_r   <= bump_r[SLOT_W-1:0];
              cap_r        <= doubled[STW-1:0];
              bump_r       <= end_w[STW-1:0];
            end
          end else begin
            res_status_r <= ST_ALLOC;
            res_slot_r   <= bump_r[SLOT_W-1:0];
            res_grew_r   <= 1'b0;
            bump_r       <= end_w[STW-1:0];
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_slot_r   <= res_slot_r;
            out_offset_r <= OFFSET_W'(res_slot_r) * OFFSET_W'(inc_r);
            out_status_r <= res_status_r;
            out_grew_r   <= res_grew_r;
            out_cap_r    <= cap_r[CAP_W-1:0];
            out_next_r   <= bump_r[UNITS_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // the user must send register writes only while idle; the block itself does not enforce it
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_INIT_CAP:   cap_r <= STW'(cfg_ch.data);
          CFG_HANDLE_INC: inc_r <= cfg_ch.data[INC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.slot              = out_slot_r;
  assign out_ch.descriptor_offset = out_offset_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.grew              = out_grew_r;
  assign out_ch.capacity          = out_cap_r;
  assign out_ch.next_free         = out_next_r;

endmodule

@@ rtl/core/ffsa_checker.sv @@
// Port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps
module ffsa_checker import ffsa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SLOT_W-1:0]   out_slot,
  input logic [OFFSET_W-1:0] out_offset,
  input logic [1:0]          out_status,
  input logic                out_grew
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_status))
    else $error("result word changed while stalled");

  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ALLOC |-> out_slot == '0 && out_offset == '0 && !out_grew)
    else $error("release or error word carries a slot");

  a_grew_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_grew |-> out_status == ST_ALLOC)
    else $error("growth flagged on a non-allocate word");

  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind first_fit_slot_allocator_top ffsa_checker u_ffsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_slot   (out_ch.slot),
  .out_offset (out_ch.descriptor_offset),
  .out_status (out_ch.status),
  .out_grew   (out_ch.grew)
);

@@ sim/tb_first_fit_slot_allocator_top.sv @@
// Self-checking testbench for the first-fit slot allocator: directed and random words.
`timescale 1ns / 1ps
module tb_first_fit_slot_allocator_top;
  import ffsa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic               func;
    logic [BYTES_W-1:0] alloc_bytes;
    logic [SLOT_W-1:0]  release_start;
    logic [UNITS_W-1:0] release_units;
  } alloc_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] descriptor_offset;
    status_t             status;
    logic                grew;
    logic [CAP_W-1:0]    capacity;
    logic [UNITS_W-1:0]  next_free;
  } alloc_rsp_t;

  // Tracks heap state and holds the responses still owed by the block.
  class heap_scoreboard;
    logic [INC_W-1:0]   handle_inc;
    logic [SLOT_W-1:0]  span_start[DEF_FREE_ENTRIES];
    logic [UNITS_W-1:0] span_len[DEF_FREE_ENTRIES];
    int                 span_count;
    int                 bump;
    int                 cap;
    alloc_rsp_t         owed_q[$];
    int                 errors;

    function new();
      handle_inc = HANDLE_INC_RST;
      span_count = 0;
      bump       = 0;
      cap        = int'(INIT_CAP_RST);
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_INIT_CAP) begin
        cap = int'(data[CAP_W-1:0]);
      end else if (idx == CFG_HANDLE_INC) begin
        handle_inc = data[INC_W-1:0];
      end
    endfunction

    function void note_request(alloc_req_t req);
      alloc_rsp_t rsp;
      int need;
      int hit;
      int end_slot;
      rsp = '0;
      if (req.func == FUNC_RELEASE) begin
        if (span_count >= DEF_FREE_ENTRIES) begin
          rsp.status = ST_TABLE_FULL;
        end else begin
          span_start[span_count] = req.release_start;
          span_len[span_count]   = req.release_units;
          span_count++;
          rsp.status = ST_RELEASE;
        end
      end else begin
        need = int'(req.alloc_bytes >> SLOT_SHIFT);
        hit  = -1;
        rsp.status = ST_ALLOC;
        for (int k = 0; k < span_count; k++) begin
          if (hit < 0 && int'(span_len[k]) >= need) hit = k;
        end
        if (hit >= 0) begin
          rsp.slot        = span_start[hit];
          span_start[hit] = span_start[hit] + SLOT_W'(need);
          span_len[hit]   = span_len[hit] - UNITS_W'(need);
          if (span_len[hit] == 0) begin
            // close the gap, later spans move down one place
            for (int k = hit; k + 1 < span_count; k++) begin
              span_start[k] = span_start[k + 1];
              span_len[k]   = span_len[k + 1];
            end
            span_count--;
          end
        end else begin
          end_slot = bump + need;
          if (end_slot > cap) begin
            if (cap * 2 > DEF_HEAP_SLOTS || end_slot > cap * 2) begin
              rsp.status = ST_CAP_LIMIT;
            end else begin
              cap      = cap * 2;
              rsp.grew = 1'b1;
              rsp.slot = SLOT_W'(bump);
              bump     = end_slot;
            end
          end else begin
            rsp.slot = SLOT_W'(bump);
            bump     = end_slot;
          end
        end
      end
      rsp.descriptor_offset = OFFSET_W'(int'(rsp.slot) * int'(handle_inc));
      rsp.capacity          = CAP_W'(cap);
      rsp.next_free         = UNITS_W'(bump);
      owed_q = {owed_q, rsp};
    endfunction

    function void check_result(alloc_rsp_t got);
      alloc_rsp_t exp;
      if (owed_q.size() == 0) begin
        $error("result word with nothing outstanding: slot %0d status %0d",
               got.slot, got.status);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      if (got.slot !== exp.slot) begin
        $error("slot: expected %0d, got %0d", exp.slot, got.slot);
        errors++;
      end
      if (got.descriptor_offset !== exp.descriptor_offset) begin
        $error("descriptor_offset: expected %0d, got %0d",
               exp.descriptor_offset, got.descriptor_offset);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.grew !== exp.grew) begin
        $error("grew: expected %0d, got %0d", exp.grew, got.grew);
        errors++;
      end
      if (got.capacity !== exp.capacity) begin
        $error("capacity: expected %0d, got %0d", exp.capacity, got.capacity);
        errors++;
      end
      if (got.next_free !== exp.next_free) begin
        $error("next_free: expected %0d, got %0d", exp.next_free, got.next_free);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   stall_left;
  int   cycle_count;
  heap_scoreboard sb;

  ffsa_in_if  in_ch ();
  ffsa_out_if out_ch ();
  ffsa_cfg_if cfg_ch ();

  first_fit_slot_allocator_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts, none once calm is set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm && rst_n && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_result(alloc_rsp_t'{out_ch.slot, out_ch.descriptor_offset,
                                   status_t'(out_ch.status), out_ch.grew,
                                   out_ch.capacity, out_ch.next_free});
    end
  end

  function automatic alloc_req_t alloc_word(int bytes);
    alloc_req_t req;
    req.func          = FUNC_ALLOC;
    req.alloc_bytes   = BYTES_W'(bytes);
    req.release_start = SLOT_W'($urandom);
    req.release_units = UNITS_W'($urandom_range(0, 4096));
    return req;
  endfunction

  function automatic alloc_req_t release_word(int first, int units);
    alloc_req_t req;
    req.func          = FUNC_RELEASE;
    req.alloc_bytes   = BYTES_W'($urandom_range(0, 1048576));
    req.release_start = SLOT_W'(first);
    req.release_units = UNITS_W'(units);
    return req;
  endfunction

  function automatic alloc_req_t random_word(int release_pct);
    int pick;
    int units;
    pick = $urandom_range(0, 99);
    if (pick < release_pct) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) units = 0;
      else if (pick < 3) units = $urandom_range(0, 4096);
      else units = $urandom_range(1, 48);
      return release_word($urandom_range(0, 4095), units);
    end
    // mostly small runs so the bump pointer climbs slowly
    if ($urandom_range(0, 9) == 0) return alloc_word($urandom_range(0, 1048576));
    return alloc_word($urandom_range(0, 40 * 256 + 255));
  endfunction

  task automatic send_request(alloc_req_t req);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= req.func;
    in_ch.alloc_bytes   <= req.alloc_bytes;
    in_ch.release_start <= req.release_start;
    in_ch.release_units <= req.release_units;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(idx, CFG_DATA_W'(value));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending and wait for every owed result before touching registers.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_random(int count, int release_pct, int calm_from);
    for (int i = 0; i < count; i++) begin
      if (i >= calm_from) calm = 1'b1;
      send_request(random_word(release_pct));
    end
    settle();
  endtask

  initial begin
    sb                  = new();
    calm                = 1'b0;
    stall_left          = 0;
    cycle_count         = 0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_ALLOC;
    in_ch.alloc_bytes   = '0;
    in_ch.release_start = '0;
    in_ch.release_units = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_INIT_CAP;
    cfg_ch.data         = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero-slot and 100-slot requests straight off the bump pointer
    send_request(alloc_word(0));
    send_request(alloc_word(255));
    send_request(alloc_word(100 * 256));
    // past capacity: one doubling
    send_request(alloc_word(200 * 256));
    // lands exactly on the capacity, no growth
    send_request(alloc_word(212 * 256));
    // too big even after doubling
    send_request(alloc_word(1048576));
    send_request(release_word(4094, 10));
    send_request(release_word(0, 0));
    send_request(release_word(4095, 4096));
    // span start wraps past slot 4095
    send_request(alloc_word(5 * 256));
    send_request(alloc_word(0));
    // drains the head span to length zero
    send_request(alloc_word(5 * 256 + 255));
    // zero-length head span is removed by a zero-slot request
    send_request(alloc_word(0));
    send_request(alloc_word(1048575 - 2095 * 256 - 255));
    send_request(alloc_word(2097 * 256));
    send_request(alloc_word(1048575));

    run_random(100, 40, 100);
    write_reg(CFG_INIT_CAP, 4096);
    write_reg(CFG_HANDLE_INC, 1024);
    run_random(70, 60, 70);
    write_reg(CFG_INIT_CAP, 1);
    write_reg(CFG_HANDLE_INC, 1);
    run_random(60, 30, 60);
    write_reg(CFG_INIT_CAP, 0);
    write_reg(CFG_HANDLE_INC, 0);
    run_random(40, 50, 40);
    write_reg(CFG_HANDLE_INC, $urandom_range(1, 1024));
    write_reg(CFG_INIT_CAP, $urandom_range(1, 4096));
    run_random(130, 45, 70);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
